// ----- sv/lox_token_scanner_top_macros.svh -----
// Assertion macros shared by the scanner's checking code
`ifndef LOX_TOKEN_SCANNER_TOP_MACROS_SVH
`define LOX_TOKEN_SCANNER_TOP_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define LTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define LTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lts_pkg.sv -----
package lts_pkg;

	// token kinds
	localparam logic [4:0] K_LPAREN    = 5'd0;
	localparam logic [4:0] K_RPAREN    = 5'd1;
	localparam logic [4:0] K_LBRACE    = 5'd2;
	localparam logic [4:0] K_RBRACE    = 5'd3;
	localparam logic [4:0] K_COMMA     = 5'd4;
	localparam logic [4:0] K_DOT       = 5'd5;
	localparam logic [4:0] K_MINUS     = 5'd6;
	localparam logic [4:0] K_PLUS      = 5'd7;
	localparam logic [4:0] K_SEMICOLON = 5'd8;
	localparam logic [4:0] K_SLASH     = 5'd9;
	localparam logic [4:0] K_STAR      = 5'd10;
	localparam logic [4:0] K_BANG      = 5'd11;
	localparam logic [4:0] K_BANG_EQ   = 5'd12;
	localparam logic [4:0] K_EQ        = 5'd13;
	localparam logic [4:0] K_EQ_EQ     = 5'd14;
	localparam logic [4:0] K_GT        = 5'd15;
	localparam logic [4:0] K_GE        = 5'd16;
	localparam logic [4:0] K_LT        = 5'd17;
	localparam logic [4:0] K_LE        = 5'd18;
	localparam logic [4:0] K_IDENT     = 5'd19;
	localparam logic [4:0] K_STRING    = 5'd20;
	localparam logic [4:0] K_NUMBER    = 5'd21;
	localparam logic [4:0] K_INVALID   = 5'd22;
	localparam logic [4:0] K_END       = 5'd23;

	// most tokens kept for one byte; lts_front drops any beyond these
	localparam int unsigned MAX_TOK = 4;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic [15:0] line;
	} token_t;

	// up to MAX_TOK tokens caused by one byte, oldest in slot 0
	typedef struct packed {
		token_t [MAX_TOK-1:0] tok;
		logic [2:0]           cnt;
	} bundle_t;

endpackage

// ----- sv/lts_front.sv -----
module lts_front #(
	parameter int OFFSET_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output lts_pkg::bundle_t  bundle,
	output logic              bundle_valid
);
	import lts_pkg::*;

	// scan modes
	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_IDENT = 4'd1;
	localparam logic [3:0] M_NUM   = 4'd2;
	localparam logic [3:0] M_NUMPT = 4'd3;
	localparam logic [3:0] M_STR   = 4'd4;
	localparam logic [3:0] M_SLASH = 4'd5;
	localparam logic [3:0] M_CMT   = 4'd6;
	localparam logic [3:0] M_LT    = 4'd7;
	localparam logic [3:0] M_GT    = 4'd8;
	localparam logic [3:0] M_BANG  = 4'd9;
	localparam logic [3:0] M_EQ    = 4'd10;

	// characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	localparam int NCAND = 6;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [15:0] sat16(input logic [15:0] v, input logic [1:0] a);
		logic [16:0] s;
		s = {1'b0, v} + {15'b0, a};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// low 16 bits of an offset, zero filled for narrow offsets
	function automatic logic [15:0] off16(input logic [OFFSET_BITS-1:0] x);
		logic [OFFSET_BITS+15:0] e;
		e = {16'b0, x};
		return e[15:0];
	endfunction

	// one-character kind of a pending operator; the two-character kind is one above
	function automatic logic [4:0] op_kind(input logic [3:0] m);
		case (m)
			M_LT:    return K_LT;
			M_GT:    return K_GT;
			M_BANG:  return K_BANG;
			default: return K_EQ;
		endcase
	endfunction

	function automatic token_t mk(input logic [4:0] k, input logic [15:0] o,
			input logic [15:0] l, input logic [15:0] ln);
		token_t t;
		t.kind   = k;
		t.offset = o;
		t.length = l;
		t.line   = ln;
		return t;
	endfunction

	logic [3:0]             mode_q, mode_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [15:0]            len_q, len_n;
	logic [15:0]            line_q, line_n;
	logic [OFFSET_BITS-1:0] boff_q, boff_n;
	logic                   seen_q, seen_n;

	logic                   do_idle;
	logic                   is_end;
	logic [NCAND-1:0]       cand_v;
	token_t [NCAND-1:0]     cand_t;
	logic [2:0]             cnt;

	// next state and the tokens of this byte
	// slots 0..1 close the running token, slot 2 is a fresh single token,
	// slots 3..4 flush a pending token at end of text, slot 5 is END
	always_comb begin
		mode_n  = mode_q;
		start_n = start_q;
		len_n   = len_q;
		line_n  = line_q;
		seen_n  = seen_q;
		boff_n  = boff_q;
		cand_v  = '0;
		cand_t  = '0;
		do_idle = 1'b0;
		is_end  = (text_byte == CH_NUL) || end_of_text;

		if (text_byte != CH_NUL) begin
			case (mode_q)
				M_IDENT: begin
					if (is_letter(text_byte) || is_digit(text_byte)) begin
						len_n = sat16(len_q, 2'd1);
					end else begin
						cand_v[0] = 1'b1;
						cand_t[0] = mk(K_IDENT, off16(start_q), len_q, line_q);
						do_idle   = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit(text_byte)) begin
						len_n = sat16(len_q, 2'd1);
					end else if (text_byte == CH_POINT && !seen_q) begin
						mode_n = M_NUMPT;
					end else begin
						cand_v[0] = 1'b1;
						cand_t[0] = mk(K_NUMBER, off16(start_q), len_q, line_q);
						do_idle   = 1'b1;
					end
				end
				M_NUMPT: begin
					if (is_digit(text_byte)) begin
						seen_n = 1'b1;
						len_n  = sat16(len_q, 2'd2);
						mode_n = M_NUM;
					end else begin
						// the point had no digit after it: it stands alone
						cand_v[0] = 1'b1;
						cand_t[0] = mk(K_NUMBER, off16(start_q), len_q, line_q);
						cand_v[1] = 1'b1;
						cand_t[1] = mk(K_DOT, off16(boff_q - 1'b1), 16'd0, line_q);
						do_idle   = 1'b1;
					end
				end
				M_STR: begin
					if (text_byte == CH_QUOTE) begin
						cand_v[0] = 1'b1;
						cand_t[0] = mk(K_STRING, off16(start_q), len_q, line_q);
						mode_n    = M_IDLE;
					end else begin
						if (text_byte == CH_NL) begin
							line_n = sat16(line_q, 2'd1);
						end
						len_n = sat16(len_q, 2'd1);
					end
				end
				M_SLASH: begin
					if (text_byte == CH_SLASH) begin
						mode_n = M_CMT;
					end else begin
						cand_v[0] = 1'b1;
						cand_t[0] = mk(K_SLASH, off16(start_q), 16'd0, line_q);
						do_idle   = 1'b1;
					end
				end
				M_CMT: begin
					if (text_byte == CH_NL) begin
						line_n = sat16(line_q, 2'd1);
						mode_n = M_IDLE;
					end
				end
				M_LT, M_GT, M_BANG, M_EQ: begin
					cand_v[0] = 1'b1;
					if (text_byte == CH_EQ) begin
						cand_t[0] = mk(op_kind(mode_q) + 5'd1, off16(start_q), 16'd0, line_q);
						mode_n    = M_IDLE;
					end else begin
						cand_t[0] = mk(op_kind(mode_q), off16(start_q), 16'd0, line_q);
						do_idle   = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			// byte seen between tokens
			if (do_idle) begin
				mode_n = M_IDLE;
				if (is_letter(text_byte) || is_digit(text_byte)) begin
					mode_n  = is_digit(text_byte) ? M_NUM : M_IDENT;
					start_n = boff_q;
					len_n   = 16'd1;
					seen_n  = 1'b0;
				end else begin
					cand_t[2] = mk(K_INVALID, off16(boff_q), 16'd0, line_q);
					case (text_byte)
						CH_LT: begin
							mode_n  = M_LT;
							start_n = boff_q;
						end
						CH_GT: begin
							mode_n  = M_GT;
							start_n = boff_q;
						end
						CH_BANG: begin
							mode_n  = M_BANG;
							start_n = boff_q;
						end
						CH_EQ: begin
							mode_n  = M_EQ;
							start_n = boff_q;
						end
						CH_SLASH: begin
							mode_n  = M_SLASH;
							start_n = boff_q;
						end
						CH_QUOTE: begin
							mode_n  = M_STR;
							start_n = boff_q + 1'b1;
							len_n   = 16'd0;
						end
						CH_SPACE, CH_TAB, CH_CR: begin
						end
						CH_NL: begin
							line_n = sat16(line_q, 2'd1);
						end
						CH_LPAR: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_LPAREN;
						end
						CH_RPAR: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_RPAREN;
						end
						CH_LBRC: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_LBRACE;
						end
						CH_RBRC: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_RBRACE;
						end
						CH_COMMA: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_COMMA;
						end
						CH_POINT: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_DOT;
						end
						CH_MINUS: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_MINUS;
						end
						CH_PLUS: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_PLUS;
						end
						CH_SEMI: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_SEMICOLON;
						end
						CH_STAR: begin
							cand_v[2] = 1'b1;
							cand_t[2].kind = K_STAR;
						end
						default: begin
							cand_v[2] = 1'b1;
						end
					endcase
				end
			end
			boff_n = boff_q + 1'b1;
		end

		// end of text: flush what is pending, then END, then restart
		if (is_end) begin
			case (mode_n)
				M_IDENT: begin
					cand_v[3] = 1'b1;
					cand_t[3] = mk(K_IDENT, off16(start_n), len_n, line_n);
				end
				M_NUM: begin
					cand_v[3] = 1'b1;
					cand_t[3] = mk(K_NUMBER, off16(start_n), len_n, line_n);
				end
				M_NUMPT: begin
					cand_v[3] = 1'b1;
					cand_t[3] = mk(K_NUMBER, off16(start_n), len_n, line_n);
					cand_v[4] = 1'b1;
					cand_t[4] = mk(K_DOT, off16(boff_n - 1'b1), 16'd0, line_n);
				end
				M_STR: begin
					// unterminated string
					cand_v[3] = 1'b1;
					cand_t[3] = mk(K_INVALID, off16(start_n), 16'd0, line_n);
				end
				M_SLASH: begin
					cand_v[3] = 1'b1;
					cand_t[3] = mk(K_SLASH, off16(start_n), 16'd0, line_n);
				end
				M_LT, M_GT, M_BANG, M_EQ: begin
					cand_v[3] = 1'b1;
					cand_t[3] = mk(op_kind(mode_n), off16(start_n), 16'd0, line_n);
				end
				default: begin
				end
			endcase
			cand_v[5] = 1'b1;
			cand_t[5] = mk(K_END, off16(boff_n), 16'd0, line_n);
			mode_n    = M_IDLE;
			boff_n    = '0;
			line_n    = 16'd1;
			len_n     = 16'd0;
			seen_n    = 1'b0;
		end
	end

	// pack the valid tokens in order, dropping any beyond the fourth
	always_comb begin
		bundle = '0;
		cnt    = 3'd0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_v[i] && cnt < 3'(MAX_TOK)) begin
				bundle.tok[cnt[1:0]] = cand_t[i];
				cnt = cnt + 3'd1;
			end
		end
		bundle.cnt   = cnt;
		bundle_valid = accept && (cnt != 3'd0);
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			start_q <= '0;
			len_q   <= 16'd0;
			line_q  <= 16'd1;
			boff_q  <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			start_q <= start_n;
			len_q   <= len_n;
			line_q  <= line_n;
			boff_q  <= boff_n;
			seen_q  <= seen_n;
		end
	end

endmodule

// ----- sv/lts_queue.sv -----
module lts_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  lts_pkg::bundle_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output lts_pkg::bundle_t rd_data,
	output logic             empty
);
	import lts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bundle_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// bundle storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/lts_back.sv -----
module lts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lts_pkg::bundle_t q_data,
	input  logic             q_empty,
	output logic             q_rd,
	output logic [4:0]       token_kind,
	output logic [15:0]      token_offset,
	output logic [15:0]      token_length,
	output logic [15:0]      line_number,
	output logic             last_of_run,
	output logic             empty,
	input  logic             pop
);
	import lts_pkg::*;

	bundle_t    bnd_q;
	logic [2:0] rem_q;
	logic       pop_ok;

	assign empty  = (rem_q == 3'd0);
	assign pop_ok = pop && !empty;
	// take the next bundle when nothing is shown or its last token leaves
	assign q_rd   = !q_empty && (empty || (pop_ok && rem_q == 3'd1));

	assign token_kind   = bnd_q.tok[0].kind;
	assign token_offset = bnd_q.tok[0].offset;
	assign token_length = bnd_q.tok[0].length;
	assign line_number  = bnd_q.tok[0].line;
	assign last_of_run  = (rem_q == 3'd1);

	// token payload: load a bundle or shift the next token into slot 0
	always_ff @(posedge clk) begin
		if (q_rd) begin
			bnd_q <= q_data;
		end else if (pop_ok) begin
			for (int i = 0; i < MAX_TOK - 1; i++) begin
				bnd_q.tok[i] <= bnd_q.tok[i+1];
			end
		end
	end

	// tokens still to transfer from the held bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (q_rd) begin
			rem_q <= q_data.cnt;
		end else if (pop_ok) begin
			rem_q <= rem_q - 3'd1;
		end
	end

endmodule

// ----- sv/lox_token_scanner_top.sv -----
// Streaming lexical scanner for Lox text: one source byte goes in per transfer and the tokens
// it completes come out as a queue, oldest first, one token per pop, with last_of_run set on
// the final token of each byte. A byte is taken in the cycle it is pushed whenever the bundle
// queue (QUEUE_DEPTH entries of up to four tokens) has room, so the input sustains one byte per
// cycle; the output moves one token per cycle while pop is held and tokens wait, so when bytes
// yield more than one token on average the output port sets the sustained rate and full rises
// once the queue fills. Tokens are registered in the queue and then in the back end. Byte 0 or
// end_of_text flushes the pending token, emits END unless four tokens precede it, and restarts
// offset and line count. Offsets are kept OFFSET_BITS wide and reported as their low 16 bits.
`include "lox_token_scanner_top_macros.svh"

module lox_token_scanner_top #(
	parameter int OFFSET_BITS = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic        push,
	output logic        full,
	output logic [4:0]  token_kind,
	output logic [15:0] token_offset,
	output logic [15:0] token_length,
	output logic [15:0] line_number,
	output logic        last_of_run,
	output logic        empty,
	input  logic        pop
);
	import lts_pkg::*;

	logic    accept;
	bundle_t f_bundle;
	logic    f_push;
	logic    q_full;
	logic    q_empty;
	logic    q_rd;
	bundle_t q_data;

	assign full   = q_full;
	assign accept = push && !q_full;

	// front: decode each byte into its bundle of tokens
	lts_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.bundle      (f_bundle),
		.bundle_valid(f_push)
	);

	// decoupling queue of bundles
	lts_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_push),
		.wr_data(f_bundle),
		.full   (q_full),
		.rd_en  (q_rd),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	// back: hand out tokens one transfer at a time
	lts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_data      (q_data),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.token_kind  (token_kind),
		.token_offset(token_offset),
		.token_length(token_length),
		.line_number (line_number),
		.last_of_run (last_of_run),
		.empty       (empty),
		.pop         (pop)
	);

	// an end-of-text byte always leaves at least one token behind
	`LTS_ASSERT_SAME(a_end_pushes, accept && (text_byte == 8'h00 || end_of_text), f_push, "end of text produced no tokens")

	// a waiting bundle reaches the output in the next cycle
	`LTS_ASSERT_NEXT(a_back_fills, empty && !q_empty, !empty, "queued bundle not shown")

	// the last token of a run leaves the output empty when nothing is queued
	`LTS_ASSERT_NEXT(a_run_drains, pop && !empty && last_of_run && q_empty, empty, "token shown after run drained")

endmodule
